[rtl/block_arena_allocator_unit_defines.svh]
// Assertion macros for the block arena allocator.
`ifndef BLOCK_ARENA_ALLOCATOR_UNIT_DEFINES_SVH
`define BLOCK_ARENA_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BAAU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BAAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/baau_pkg.sv]
// Shared types and constants of the block arena allocator.
package baau_pkg;

    localparam int OP_W         = 1;
    localparam int SIZE_W       = 13;
    localparam int STATUS_W     = 2;
    localparam int BLKIDX_W     = 8;
    localparam int OFFSET_W     = 12;
    localparam int GEN_W        = 16;
    localparam int CFG_BYTES_W  = 13;
    localparam int CFG_BLOCKS_W = 9;

    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_BYTES_W-1:0]  BLOCK_BYTES_RST   = CFG_BYTES_W'(4096);
    localparam logic [CFG_BLOCKS_W-1:0] BLOCKS_IN_USE_RST = CFG_BLOCKS_W'(256);

    // register index, taken from paddr[2]
    localparam logic REG_BLOCK_BYTES   = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    localparam logic [OP_W-1:0] OP_RESERVE = 1'b0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK  = 2'd2;

    typedef struct packed {
        logic [GEN_W-1:0]    generation;
        logic [OFFSET_W-1:0] byte_offset;
        logic [BLKIDX_W-1:0] block_index;
        logic [STATUS_W-1:0] status;
        logic                granted;
    } result_t;

endpackage

[rtl/baau_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module baau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/block_arena_allocator_unit.sv]
// Block arena allocator: bump allocation in equal blocks with a block free list.
//
// Requests enter on the s_ stream (s_tuser = operation, s_tdata = request size),
// one result word leaves on the m_ stream per request. Block size and block
// count are set through the APB port; the user must write them only while no
// request is in flight; the block does not enforce it. A reserve is accepted
// (fill and link RAM reads issued, aligned size quotient registered), then
// decided and written back once the output register is free. A clear walks
// the in-use chain through the link RAM one block per cycle, pushing each
// onto the free list, then reads the free-list head link and takes the new
// block once the output register is free.
// The result sits in an output register; a new request is accepted while it
// waits, and the block stalls only at the point where it must post the next
// result. Reset leaves block 0 current and empty, all others untouched, the
// free list empty and the generation count at 0; it needs no clearing pass
// since entry 0 of each RAM carries its own reset flag.
`include "block_arena_allocator_unit_defines.svh"

module block_arena_allocator_unit #(
    parameter int MAX_BLOCKS      = 256,
    parameter int MAX_BLOCK_BYTES = 4096,
    parameter int ALIGN_BYTES     = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [baau_pkg::S_TDATA_W-1:0]      s_tdata,   // [12:0] request_size
    input  logic [baau_pkg::OP_W-1:0]           s_tuser,   // [0] operation
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] granted, [2:1] status, [10:3] block_index, [22:11] byte_offset,
    // [38:23] generation
    output logic [baau_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [baau_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [baau_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [baau_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W     = $clog2(MAX_BLOCKS);
    localparam int PTR_W     = IDX_W + 1;
    localparam int CNT_W     = (PTR_W > baau_pkg::CFG_BLOCKS_W) ? PTR_W : baau_pkg::CFG_BLOCKS_W;
    localparam int BLK_MAXV  = 2**baau_pkg::CFG_BLOCKS_W - 1;
    localparam int BLK_CAP   = (MAX_BLOCKS < BLK_MAXV) ? MAX_BLOCKS : BLK_MAXV;
    localparam int BYTE_MAXV = 2**baau_pkg::CFG_BYTES_W - 1;
    localparam int BYTES_CAP = (MAX_BLOCK_BYTES < BYTE_MAXV) ? MAX_BLOCK_BYTES : BYTE_MAXV;
    localparam int X_W       = baau_pkg::SIZE_W + 1;
    localparam int FILL_W    = X_W;
    localparam int Q_W       = X_W;
    // reciprocal of the alignment, exact for every X_W-bit dividend up to 128
    localparam int RECIP_SH  = X_W + 7;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int RECIP     = (2**RECIP_SH + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PROD_W    = X_W + RECIP_W;
    localparam int AL_W      = Q_W + 7;

    localparam logic [PTR_W-1:0] NO_BLOCK = PTR_W'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WALK,
        ST_CLR_RD,
        ST_CLR_DONE
    } state_t;

    state_t                             state_reg, state_next;
    logic [baau_pkg::CFG_BYTES_W-1:0]   block_bytes_reg, block_bytes_next;
    logic [baau_pkg::CFG_BLOCKS_W-1:0]  blocks_in_use_reg, blocks_in_use_next;
    logic [PTR_W-1:0]                   fresh_index_reg, fresh_index_next;
    logic [PTR_W-1:0]                   cur_head_reg, cur_head_next;
    logic                               cur_valid_reg, cur_valid_next;
    logic [PTR_W-1:0]                   free_head_reg, free_head_next;
    logic [baau_pkg::GEN_W-1:0]         clear_count_reg, clear_count_next;
    logic                               fill0_vld_reg, fill0_vld_next;
    logic                               link0_vld_reg, link0_vld_next;
    logic                               fill_rz_reg, fill_rz_next;
    logic                               link_rz_reg, link_rz_next;
    logic [baau_pkg::SIZE_W-1:0]        size_reg, size_next;
    logic [Q_W-1:0]                     quot_reg, quot_next;
    logic                               out_valid_reg, out_valid_next;
    baau_pkg::result_t                  res_reg, res_next;

    logic                               fill_we, fill_re;
    logic [IDX_W-1:0]                   fill_waddr, fill_raddr;
    logic [FILL_W-1:0]                  fill_wdata, fill_rdata;
    logic                               link_we, link_re;
    logic [IDX_W-1:0]                   link_waddr, link_raddr;
    logic [PTR_W-1:0]                   link_wdata, link_rdata;

    logic                               cfg_wr;
    logic                               out_free;
    logic                               out_load;
    logic [baau_pkg::CFG_BYTES_W-1:0]   eff_bytes;
    logic [CNT_W-1:0]                   eff_blocks;
    logic                               fresh_ok;
    logic                               free_ok;
    logic [PTR_W-1:0]                   take_idx;
    logic [FILL_W-1:0]                  fill_rd_val;
    logic [PTR_W-1:0]                   link_rd_val;
    logic [X_W-1:0]                     size_biased;
    logic [PROD_W-1:0]                  recip_prod;
    logic [AL_W-1:0]                    size_al_wide;
    logic [FILL_W-1:0]                  size_al;
    logic                               too_large;
    logic                               fits;

    function automatic logic [baau_pkg::BLKIDX_W-1:0] to_blk(input logic [PTR_W-1:0] v);
        logic [PTR_W+baau_pkg::BLKIDX_W-1:0] ext;
        ext = (PTR_W + baau_pkg::BLKIDX_W)'(v);
        return ext[baau_pkg::BLKIDX_W-1:0];
    endfunction

    baau_ram #(
        .WIDTH (FILL_W),
        .DEPTH (MAX_BLOCKS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    baau_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == baau_pkg::REG_BLOCKS_IN_USE)
                    ? baau_pkg::APB_DATA_W'(blocks_in_use_reg)
                    : baau_pkg::APB_DATA_W'(block_bytes_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = baau_pkg::M_TDATA_W'(res_reg);
    assign out_free = !out_valid_reg || m_tready;

    assign eff_bytes  = (block_bytes_reg > baau_pkg::CFG_BYTES_W'(BYTES_CAP))
                      ? baau_pkg::CFG_BYTES_W'(BYTES_CAP) : block_bytes_reg;
    assign eff_blocks = (CNT_W'(blocks_in_use_reg) > CNT_W'(BLK_CAP))
                      ? CNT_W'(BLK_CAP) : CNT_W'(blocks_in_use_reg);
    assign fresh_ok   = CNT_W'(fresh_index_reg) < eff_blocks;
    assign free_ok    = free_head_reg != NO_BLOCK;
    assign take_idx   = fresh_ok ? fresh_index_reg : free_head_reg;

    // entry 0 reads as its reset value until first written
    assign fill_rd_val = fill_rz_reg ? '0 : fill_rdata;
    assign link_rd_val = link_rz_reg ? NO_BLOCK : link_rdata;

    // align_up(size) = ceil(size / ALIGN) * ALIGN, quotient through the reciprocal
    assign size_biased  = X_W'(s_tdata[baau_pkg::SIZE_W-1:0]) + X_W'(ALIGN_BYTES - 1);
    assign recip_prod   = PROD_W'(size_biased) * PROD_W'(RECIP);
    assign size_al_wide = AL_W'(quot_reg) * AL_W'(ALIGN_BYTES);
    assign size_al      = size_al_wide[FILL_W-1:0];

    assign too_large = size_reg > eff_bytes;
    assign fits      = ((FILL_W + 1)'(fill_rd_val) + (FILL_W + 1)'(size_reg))
                       <= (FILL_W + 1)'(eff_bytes);

    always_comb
    begin
        state_next         = state_reg;
        block_bytes_next   = block_bytes_reg;
        blocks_in_use_next = blocks_in_use_reg;
        fresh_index_next   = fresh_index_reg;
        cur_head_next      = cur_head_reg;
        cur_valid_next     = cur_valid_reg;
        free_head_next     = free_head_reg;
        clear_count_next   = clear_count_reg;
        size_next          = size_reg;
        quot_next          = quot_reg;
        res_next           = res_reg;
        out_load           = 1'b0;
        fill_we            = 1'b0;
        fill_waddr         = '0;
        fill_wdata         = '0;
        fill_re            = 1'b0;
        fill_raddr         = '0;
        link_we            = 1'b0;
        link_waddr         = '0;
        link_wdata         = '0;
        link_re            = 1'b0;
        link_raddr         = '0;

        if (cfg_wr)
        begin
            if (paddr[2] == baau_pkg::REG_BLOCK_BYTES)
            begin
                block_bytes_next = pwdata[baau_pkg::CFG_BYTES_W-1:0];
            end
            else
            begin
                blocks_in_use_next = pwdata[baau_pkg::CFG_BLOCKS_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    size_next = s_tdata[baau_pkg::SIZE_W-1:0];
                    quot_next = recip_prod[RECIP_SH +: Q_W];
                    link_re   = 1'b1;
                    if (s_tuser == baau_pkg::OP_CLEAR)
                    begin
                        link_raddr = cur_head_reg[IDX_W-1:0];
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        fill_re    = 1'b1;
                        fill_raddr = cur_head_reg[IDX_W-1:0];
                        link_raddr = free_head_reg[IDX_W-1:0];
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_load            = 1'b1;
                    state_next          = ST_IDLE;
                    res_next.generation = clear_count_reg;
                    res_next.byte_offset = '0;
                    res_next.granted    = 1'b0;
                    res_next.block_index = cur_valid_reg ? to_blk(cur_head_reg) : '0;
                    if (too_large)
                    begin
                        res_next.status = baau_pkg::STATUS_TOO_LARGE;
                    end
                    else if (cur_valid_reg && fits)
                    begin
                        // the stored fill is kept aligned
                        fill_we              = 1'b1;
                        fill_waddr           = cur_head_reg[IDX_W-1:0];
                        fill_wdata           = fill_rd_val + size_al;
                        res_next.granted     = 1'b1;
                        res_next.status      = baau_pkg::STATUS_OK;
                        res_next.byte_offset = fill_rd_val[baau_pkg::OFFSET_W-1:0];
                    end
                    else if (fresh_ok || free_ok)
                    begin
                        fill_we    = 1'b1;
                        fill_waddr = take_idx[IDX_W-1:0];
                        fill_wdata = size_al;
                        link_we    = 1'b1;
                        link_waddr = take_idx[IDX_W-1:0];
                        link_wdata = cur_valid_reg ? cur_head_reg : NO_BLOCK;
                        if (fresh_ok)
                        begin
                            fresh_index_next = fresh_index_reg + PTR_W'(1);
                        end
                        else
                        begin
                            free_head_next = link_rd_val;
                        end
                        cur_head_next        = take_idx;
                        cur_valid_next       = 1'b1;
                        res_next.granted     = 1'b1;
                        res_next.status      = baau_pkg::STATUS_OK;
                        res_next.block_index = to_blk(take_idx);
                    end
                    else
                    begin
                        res_next.status = baau_pkg::STATUS_NO_BLOCK;
                    end
                end
            end

            ST_WALK:
            begin
                // one chain block per cycle: push it, read the next link
                if (cur_valid_reg)
                begin
                    link_we        = 1'b1;
                    link_waddr     = cur_head_reg[IDX_W-1:0];
                    link_wdata     = free_head_reg;
                    free_head_next = cur_head_reg;
                    if (link_rd_val != NO_BLOCK)
                    begin
                        cur_head_next = link_rd_val;
                        link_re       = 1'b1;
                        link_raddr    = link_rd_val[IDX_W-1:0];
                    end
                    else
                    begin
                        cur_valid_next = 1'b0;
                        state_next     = ST_CLR_RD;
                    end
                end
                else
                begin
                    state_next = ST_CLR_RD;
                end
            end

            ST_CLR_RD:
            begin
                link_re    = 1'b1;
                link_raddr = free_head_reg[IDX_W-1:0];
                state_next = ST_CLR_DONE;
            end

            ST_CLR_DONE:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    state_next           = ST_IDLE;
                    res_next.byte_offset = '0;
                    if (fresh_ok || free_ok)
                    begin
                        fill_we    = 1'b1;
                        fill_waddr = take_idx[IDX_W-1:0];
                        fill_wdata = '0;
                        link_we    = 1'b1;
                        link_waddr = take_idx[IDX_W-1:0];
                        link_wdata = NO_BLOCK;
                        if (fresh_ok)
                        begin
                            fresh_index_next = fresh_index_reg + PTR_W'(1);
                        end
                        else
                        begin
                            free_head_next = link_rd_val;
                        end
                        cur_head_next        = take_idx;
                        cur_valid_next       = 1'b1;
                        clear_count_next     = clear_count_reg + baau_pkg::GEN_W'(1);
                        res_next.granted     = 1'b1;
                        res_next.status      = baau_pkg::STATUS_OK;
                        res_next.block_index = to_blk(take_idx);
                        res_next.generation  = clear_count_reg + baau_pkg::GEN_W'(1);
                    end
                    else
                    begin
                        cur_head_next        = '0;
                        cur_valid_next       = 1'b0;
                        res_next.granted     = 1'b0;
                        res_next.status      = baau_pkg::STATUS_NO_BLOCK;
                        res_next.block_index = '0;
                        res_next.generation  = clear_count_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        fill0_vld_next = fill0_vld_reg || (fill_we && (fill_waddr == '0));
        link0_vld_next = link0_vld_reg || (link_we && (link_waddr == '0));
        fill_rz_next   = fill_re ? ((fill_raddr == '0) && !fill0_vld_reg) : fill_rz_reg;
        link_rz_next   = link_re ? ((link_raddr == '0) && !link0_vld_reg) : link_rz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            block_bytes_reg   <= baau_pkg::BLOCK_BYTES_RST;
            blocks_in_use_reg <= baau_pkg::BLOCKS_IN_USE_RST;
            fresh_index_reg   <= PTR_W'(1);
            cur_head_reg      <= '0;
            cur_valid_reg     <= 1'b1;
            free_head_reg     <= NO_BLOCK;
            clear_count_reg   <= '0;
            fill0_vld_reg     <= 1'b0;
            link0_vld_reg     <= 1'b0;
            fill_rz_reg       <= 1'b0;
            link_rz_reg       <= 1'b0;
            size_reg          <= '0;
            quot_reg          <= '0;
            out_valid_reg     <= 1'b0;
            res_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            block_bytes_reg   <= block_bytes_next;
            blocks_in_use_reg <= blocks_in_use_next;
            fresh_index_reg   <= fresh_index_next;
            cur_head_reg      <= cur_head_next;
            cur_valid_reg     <= cur_valid_next;
            free_head_reg     <= free_head_next;
            clear_count_reg   <= clear_count_next;
            fill0_vld_reg     <= fill0_vld_next;
            link0_vld_reg     <= link0_vld_next;
            fill_rz_reg       <= fill_rz_next;
            link_rz_reg       <= link_rz_next;
            size_reg          <= size_next;
            quot_reg          <= quot_next;
            out_valid_reg     <= out_valid_next;
            res_reg           <= res_next;
        end
    end

    `BAAU_ASSERT_SAME(a_link_rw_apart, link_we && link_re, link_waddr != link_raddr, "link RAM read and write on one entry")
    `BAAU_ASSERT_SAME(a_fill_rw_apart, fill_we, !fill_re, "fill RAM read during write back")
    `BAAU_ASSERT_SAME(a_walk_in_range, (state_reg == ST_WALK) && cur_valid_reg, cur_head_reg != NO_BLOCK, "chain walk on the empty marker")
    `BAAU_ASSERT_NEXT(a_grant_sets_current, out_load && res_next.granted, cur_valid_reg, "granted word without a current block")

endmodule

[sim/arena_grant_checker.sv]
// Checker for the block arena allocator: tracks pool state, predicts each result and compares.
module arena_grant_checker #(
    parameter int MAX_BLOCKS      = 256,
    parameter int MAX_BLOCK_BYTES = 4096,
    parameter int ALIGN_BYTES     = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [baau_pkg::S_TDATA_W-1:0]      s_tdata,    // [12:0] request_size
    input  logic [baau_pkg::OP_W-1:0]           s_tuser,    // [0] operation
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] granted, [2:1] status, [10:3] block_index, [22:11] byte_offset,
    // [38:23] generation
    input  logic [baau_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [baau_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [baau_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                                pready,
    output int                                  outstanding,
    output int                                  mismatches
);

    timeunit 1ns;
    timeprecision 1ps;

    int cfg_bytes;
    int cfg_blocks;
    int fresh_idx;
    int head_blk;
    bit head_ok;
    int free_top;
    int gen_count;
    int next_blk [MAX_BLOCKS];
    int fill_bytes [MAX_BLOCKS];
    int fail_total;
    baau_pkg::result_t pending_grants [$];

    function automatic int align_up(input int x);
        int a;
        a = (ALIGN_BYTES < 1) ? 1 : ALIGN_BYTES;
        return ((x + a - 1) / a) * a;
    endfunction

    // Next untouched block first, then the free list; the new block heads the chain.
    function automatic bit claim_block();
        int idx;
        int limit;
        limit = (cfg_blocks > MAX_BLOCKS) ? MAX_BLOCKS : cfg_blocks;
        if (fresh_idx < limit)
        begin
            idx = fresh_idx;
            fresh_idx++;
        end
        else if (free_top < MAX_BLOCKS)
        begin
            idx = free_top;
            free_top = next_blk[idx];
        end
        else
        begin
            return 1'b0;
        end
        fill_bytes[idx] = 0;
        next_blk[idx] = head_ok ? head_blk : MAX_BLOCKS;
        head_blk = idx;
        head_ok = 1'b1;
        return 1'b1;
    endfunction

    function automatic baau_pkg::result_t predict_grant(input logic [baau_pkg::OP_W-1:0] op,
                                                        input int size);
        baau_pkg::result_t r;
        int bytes;
        int off;
        int blk;
        int nxt;
        int steps;
        bit placed;
        r = '0;
        placed = 1'b0;
        bytes = (cfg_bytes > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : cfg_bytes;
        if (op == baau_pkg::OP_CLEAR)
        begin
            steps = 0;
            while (head_ok && head_blk < MAX_BLOCKS && steps < MAX_BLOCKS)
            begin
                blk = head_blk;
                nxt = next_blk[blk];
                next_blk[blk] = free_top;
                free_top = blk;
                if (nxt < MAX_BLOCKS)
                    head_blk = nxt;
                else
                    head_ok = 1'b0;
                steps++;
            end
            head_ok = 1'b0;
            head_blk = 0;
            if (claim_block())
            begin
                gen_count = (gen_count + 1) & 16'hFFFF;
                r.granted = 1'b1;
                r.status = baau_pkg::STATUS_OK;
                r.block_index = baau_pkg::BLKIDX_W'(head_blk);
            end
            else
            begin
                r.status = baau_pkg::STATUS_NO_BLOCK;
            end
        end
        else if (size > bytes)
        begin
            r.status = baau_pkg::STATUS_TOO_LARGE;
            r.block_index = head_ok ? baau_pkg::BLKIDX_W'(head_blk) : '0;
        end
        else
        begin
            if (head_ok)
            begin
                off = align_up(fill_bytes[head_blk]);
                if (off <= bytes && bytes - off >= size)
                begin
                    fill_bytes[head_blk] = off + size;
                    r.granted = 1'b1;
                    r.status = baau_pkg::STATUS_OK;
                    r.block_index = baau_pkg::BLKIDX_W'(head_blk);
                    r.byte_offset = baau_pkg::OFFSET_W'(off);   // 4096 wraps to 0
                    placed = 1'b1;
                end
            end
            if (!placed)
            begin
                if (!claim_block())
                begin
                    r.status = baau_pkg::STATUS_NO_BLOCK;
                    r.block_index = head_ok ? baau_pkg::BLKIDX_W'(head_blk) : '0;
                end
                else
                begin
                    fill_bytes[head_blk] = size;
                    r.granted = 1'b1;
                    r.status = baau_pkg::STATUS_OK;
                    r.block_index = baau_pkg::BLKIDX_W'(head_blk);
                end
            end
        end
        r.generation = baau_pkg::GEN_W'(gen_count);
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        baau_pkg::result_t want;
        baau_pkg::result_t got;
        if (!rst_n)
        begin
            cfg_bytes = baau_pkg::BLOCK_BYTES_RST;
            cfg_blocks = baau_pkg::BLOCKS_IN_USE_RST;
            fresh_idx = 1;
            head_blk = 0;
            head_ok = 1'b1;
            free_top = MAX_BLOCKS;
            gen_count = 0;
            foreach (next_blk[i])
            begin
                next_blk[i] = 0;
                fill_bytes[i] = 0;
            end
            next_blk[0] = MAX_BLOCKS;
            pending_grants.delete();
            fail_total = 0;
            outstanding <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == baau_pkg::REG_BLOCK_BYTES)
                    cfg_bytes = pwdata[baau_pkg::CFG_BYTES_W-1:0];
                else
                    cfg_blocks = pwdata[baau_pkg::CFG_BLOCKS_W-1:0];
            end
            // retire before predicting: a word cannot answer a request taken at the same edge
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(baau_pkg::result_t)-1:0];
                if (pending_grants.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_total++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    compare_field("granted", want.granted, got.granted);
                    compare_field("status", want.status, got.status);
                    compare_field("block_index", want.block_index, got.block_index);
                    compare_field("byte_offset", want.byte_offset, got.byte_offset);
                    compare_field("generation", want.generation, got.generation);
                end
            end
            if (s_tvalid && s_tready)
                pending_grants.push_back(predict_grant(s_tuser,
                                                       s_tdata[baau_pkg::SIZE_W-1:0]));
            outstanding <= pending_grants.size();
            mismatches <= fail_total;
        end
    end

endmodule

[sim/block_arena_allocator_unit_tb.sv]
// Testbench top for the block arena allocator: clock, reset, stimulus and verdict.
module block_arena_allocator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_BYTES   = 4096;

    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [baau_pkg::S_TDATA_W-1:0]     s_tdata  = '0;     // [12:0] request_size
    logic [baau_pkg::OP_W-1:0]          s_tuser  = '0;     // [0] operation
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    // [0] granted, [2:1] status, [10:3] block_index, [22:11] byte_offset,
    // [38:23] generation
    logic [baau_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [baau_pkg::APB_ADDR_W-1:0]    paddr    = '0;
    logic [baau_pkg::APB_DATA_W-1:0]    pwdata   = '0;
    logic [baau_pkg::APB_DATA_W-1:0]    prdata;
    logic                               pready;

    int outstanding;
    int mismatches;
    int ready_mode = 0;
    int mode_left  = 0;
    int cycle_count = 0;

    block_arena_allocator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    arena_grant_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always #5 clk = ~clk;

    // receiver: runs of always-ready, coin-flip and mostly-stalled cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_mode <= 0;
            mode_left <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(8, 80);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic push_request(input logic [baau_pkg::OP_W-1:0] op,
                                input logic [baau_pkg::SIZE_W-1:0] size);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= baau_pkg::S_TDATA_W'(size);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending and wait until every issued request has been answered
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [baau_pkg::SIZE_W-1:0] pick_size(input int cap);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 8)
            return baau_pkg::SIZE_W'($urandom_range(0, (cap < 40) ? cap : 40));
        if (roll < 13)
            return baau_pkg::SIZE_W'($urandom_range(0, cap));
        if (roll < 15)
            return baau_pkg::SIZE_W'(cap);
        if (roll < 17)
            return baau_pkg::SIZE_W'($urandom_range(cap + 1, 8191));
        return baau_pkg::SIZE_W'($urandom_range(0, 8191));
    endfunction

    task automatic run_random(input int count, input int cap);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < count; i++)
        begin
            push_request(($urandom_range(0, 11) == 0) ? baau_pkg::OP_CLEAR
                                                       : baau_pkg::OP_RESERVE,
                         pick_size(cap));
            burst_left--;
            if (burst_left == 0 && i < count - 1)
            begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if ($urandom_range(0, 24) == 0)
                begin
                    settle();
                end
                else if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        settle();
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("block_arena_allocator_unit_tb failed");
        $finish;
    end

    initial
    begin
        int phase_bytes [9];
        int phase_blocks [9];
        int cap;
        phase_bytes  = '{4096, 64, 1, 8191, 24, 0, 200, 4097, 4096};
        phase_blocks = '{256, 4, 2, 511, 1, 3, 256, 0, 8};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bump fill, alignment, spill to a new block, zero size at a full block, refusals
        push_request(baau_pkg::OP_RESERVE, 0);
        push_request(baau_pkg::OP_RESERVE, 1);
        push_request(baau_pkg::OP_RESERVE, 7);
        push_request(baau_pkg::OP_RESERVE, 4096);
        push_request(baau_pkg::OP_RESERVE, 0);
        push_request(baau_pkg::OP_RESERVE, 4097);
        push_request(baau_pkg::OP_RESERVE, 8191);
        push_request(baau_pkg::OP_RESERVE, 4095);
        push_request(baau_pkg::OP_CLEAR, 8191);
        push_request(baau_pkg::OP_RESERVE, 13);
        settle();

        // zero-byte blocks refuse any nonzero size
        write_register(baau_pkg::REG_BLOCK_BYTES, 0);
        push_request(baau_pkg::OP_RESERVE, 0);
        push_request(baau_pkg::OP_RESERVE, 1);
        settle();

        // single block: run through the free list until nothing is left, then clear
        write_register(baau_pkg::REG_BLOCK_BYTES, 16);
        write_register(baau_pkg::REG_BLOCKS_IN_USE, 1);
        push_request(baau_pkg::OP_RESERVE, 16);
        push_request(baau_pkg::OP_RESERVE, 16);
        push_request(baau_pkg::OP_RESERVE, 16);
        push_request(baau_pkg::OP_RESERVE, 16);
        push_request(baau_pkg::OP_CLEAR, 0);
        push_request(baau_pkg::OP_RESERVE, 9);
        settle();

        write_register(baau_pkg::REG_BLOCKS_IN_USE, 0);
        push_request(baau_pkg::OP_RESERVE, 16);
        push_request(baau_pkg::OP_RESERVE, 16);
        push_request(baau_pkg::OP_CLEAR, 0);
        settle();

        for (int p = 0; p < 9; p++)
        begin
            write_register(baau_pkg::REG_BLOCK_BYTES, phase_bytes[p]);
            write_register(baau_pkg::REG_BLOCKS_IN_USE, phase_blocks[p]);
            cap = (phase_bytes[p] > MAX_BYTES) ? MAX_BYTES : phase_bytes[p];
            run_random(104, cap);
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("block_arena_allocator_unit_tb passed");
        else
            $display("block_arena_allocator_unit_tb failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/baau_pkg.sv
rtl/baau_ram.sv
rtl/block_arena_allocator_unit.sv
sim/arena_grant_checker.sv
sim/block_arena_allocator_unit_tb.sv
